// ----- hdl/light_fade_transition_assert.svh -----
// Assertion macros used by the fade engine controller.
`ifndef LIGHT_FADE_TRANSITION_ASSERT_SVH
`define LIGHT_FADE_TRANSITION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("light_fade_transition: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("light_fade_transition: next-cycle check failed");

`endif

// ----- hdl/lft_pkg.sv -----
package lft_pkg;

   localparam int TIME_WIDTH = 40;
   localparam int LEVEL_W    = 16;
   localparam int TICK_W     = 32;
   localparam int CFG_W      = 8;
   localparam int CODE_W     = 8;
   localparam int STEPS_W    = 6;
   localparam int RES_W      = 20;
   localparam int DUR_W      = 32;
   localparam int PROD_W     = TICK_W + CFG_W;
   localparam int DELAY5_W   = CODE_W + 3;
   localparam int CNT_W      = $clog2(TIME_WIDTH + 1);
   localparam int CSR_IDX_W  = 1;

   localparam logic [LEVEL_W-1:0] TEMP_MIN  = 16'd800;
   localparam logic [LEVEL_W-1:0] TEMP_MAX  = 16'd20000;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;
   localparam logic [STEPS_W-1:0] STEPS_UNKNOWN = 6'h3F;
   localparam logic [DUR_W-1:0]   UNKNOWN_MS    = 32'hFFFF_FFFF;
   localparam logic [CFG_W-1:0]   TICK_PERIOD_RST   = 8'd10;
   localparam logic [CFG_W-1:0]   STEP_INTERVAL_RST = 8'd10;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_SET_LEVEL = 2'd1,
      CMD_SET_ONOFF = 2'd2,
      CMD_START     = 2'd3
   } lft_cmd_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICK_PERIOD   = 1'b0,
      CSR_STEP_INTERVAL = 1'b1
   } lft_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_SET_START,
      ST_SET_END,
      ST_TICK_START,
      ST_TICK_EVAL,
      ST_DIV_STEPS,
      ST_DIV_LIGHT,
      ST_DIV_TEMP,
      ST_FINISH
   } lft_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic calc_prod;
      logic apply_level;
      logic set_start;
      logic set_end;
      logic clear_start;
      logic clear_end;
      logic save;
      logic snap;
      logic div_steps_go;
      logic div_light_go;
      logic div_temp_go;
      logic step_light;
      logic step_temp;
      logic set_drive;
      logic set_saved;
      logic load_rsp;
   } lft_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      lft_cmd_code_type command;
      logic             none_pending;
      logic             start_pending;
      logic             before_start;
      logic             at_target;
      logic             end_after_now;
      logic             trans_zero;
      logic             delay_zero;
      logic             div_idle;
      logic             steps_zero;
   } lft_status_type;

   // Start request for the shared divider.
   typedef struct packed {
      logic             go;
      logic [CNT_W-1:0] iters;
   } lft_div_cmd_type;

   // Length of one resolution unit in milliseconds.
   function automatic logic [RES_W-1:0] res_ms(input logic [1:0] sel);
      logic [RES_W-1:0] ms;
      case (sel)
         2'd0:    ms = 20'd100;
         2'd1:    ms = 20'd1000;
         2'd2:    ms = 20'd10000;
         default: ms = 20'd600000;
      endcase
      return ms;
   endfunction

   function automatic logic [DUR_W-1:0] duration_ms(input logic [CODE_W-1:0] code);
      logic [STEPS_W-1:0] steps;
      logic [DUR_W-1:0]   dur;
      steps = code[STEPS_W-1:0];
      if (steps == STEPS_UNKNOWN) begin
         dur = UNKNOWN_MS;
      end else begin
         dur = {{(DUR_W-STEPS_W){1'b0}}, steps} *
               {{(DUR_W-RES_W){1'b0}}, res_ms(code[CODE_W-1:CODE_W-2])};
      end
      return dur;
   endfunction

   function automatic logic [LEVEL_W-1:0] level_delta(input logic [LEVEL_W-1:0] cur,
                                                      input logic [LEVEL_W-1:0] tgt);
      logic [LEVEL_W-1:0] d;
      if (tgt >= cur) begin
         d = tgt - cur;
      end else begin
         d = cur - tgt;
      end
      return d;
   endfunction

   function automatic logic [LEVEL_W-1:0] level_step(input logic [LEVEL_W-1:0] cur,
                                                     input logic [LEVEL_W-1:0] tgt,
                                                     input logic [LEVEL_W-1:0] q);
      logic [LEVEL_W-1:0] v;
      if (tgt >= cur) begin
         v = cur + q;
      end else begin
         v = cur - q;
      end
      return v;
   endfunction

endpackage

// ----- hdl/lft_div.sv -----
module lft_div
   import lft_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  lft_div_cmd_type       div_cmd,
   input  logic [TIME_WIDTH-1:0] dividend,
   input  logic [TIME_WIDTH-1:0] divisor,
   output logic                  busy,
   output logic [TIME_WIDTH-1:0] quotient
);

   // Restoring divider, one quotient bit per cycle. A narrow dividend is
   // loaded left aligned and run for fewer iterations.
   logic [TIME_WIDTH-1:0] rem_ff, rem_in;
   logic [TIME_WIDTH-1:0] quot_ff, quot_in;
   logic [TIME_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic [TIME_WIDTH:0]   shifted;
   logic [TIME_WIDTH:0]   trial;

   assign shifted = {rem_ff, quot_ff[TIME_WIDTH-1]};
   assign trial   = shifted - {1'b0, dsr_ff};

   always_comb begin
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (div_cmd.go) begin
         rem_in   = '0;
         quot_in  = dividend;
         dsr_in   = divisor;
         count_in = div_cmd.iters;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[TIME_WIDTH]) begin
            rem_in  = trial[TIME_WIDTH-1:0];
            quot_in = {quot_ff[TIME_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = shifted[TIME_WIDTH-1:0];
            quot_in = {quot_ff[TIME_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// ----- hdl/lft_dpath.sv -----
module lft_dpath
   import lft_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   input  logic [1:0]           req_command,
   input  logic [LEVEL_W-1:0]   req_lightness,
   input  logic [LEVEL_W-1:0]   req_temperature,
   input  logic                 req_onoff_value,
   input  logic [CODE_W-1:0]    req_transition_code,
   input  logic [CODE_W-1:0]    req_delay_code,
   input  lft_cmd_type          cmd,
   output lft_status_type       status,
   output logic [LEVEL_W-1:0]   rsp_current_lightness,
   output logic [LEVEL_W-1:0]   rsp_current_temperature,
   output logic [LEVEL_W-1:0]   rsp_target_lightness_out,
   output logic                 rsp_target_onoff_out,
   output logic                 rsp_drive_update,
   output logic                 rsp_state_saved,
   output logic                 rsp_transition_active
);

   // Configuration.
   logic [CFG_W-1:0] period_ff, period_in;
   logic [CFG_W-1:0] interval_ff, interval_in;

   // Lamp state.
   logic [TICK_W-1:0]     tick_count_ff, tick_count_in;
   logic [TIME_WIDTH-1:0] start_ff, start_in;
   logic [TIME_WIDTH-1:0] end_ff, end_in;
   logic [LEVEL_W-1:0]    cur_l_ff, cur_l_in;
   logic [LEVEL_W-1:0]    cur_t_ff, cur_t_in;
   logic [LEVEL_W-1:0]    tgt_l_ff, tgt_l_in;
   logic [LEVEL_W-1:0]    tgt_t_ff, tgt_t_in;
   logic                  tgt_onoff_ff, tgt_onoff_in;
   logic [LEVEL_W-1:0]    saved_l_ff, saved_l_in;
   logic [LEVEL_W-1:0]    saved_t_ff, saved_t_in;
   logic                  drive_ff, drive_in;
   logic                  saved_flag_ff, saved_flag_in;

   // Captured item and working values.
   lft_cmd_code_type      req_cmd_ff, req_cmd_in;
   logic [LEVEL_W-1:0]    req_l_ff, req_l_in;
   logic [LEVEL_W-1:0]    req_t_ff, req_t_in;
   logic                  req_onoff_ff, req_onoff_in;
   logic [CODE_W-1:0]     req_trans_ff, req_trans_in;
   logic [CODE_W-1:0]     req_delay_ff, req_delay_in;
   logic [TIME_WIDTH-1:0] prod_ff, prod_in;
   logic [DUR_W-1:0]      dur_ff, dur_in;
   logic [TIME_WIDTH-1:0] steps_ff, steps_in;

   // Result register.
   logic [LEVEL_W-1:0] out_cur_l_ff, out_cur_l_in;
   logic [LEVEL_W-1:0] out_cur_t_ff, out_cur_t_in;
   logic [LEVEL_W-1:0] out_tgt_l_ff, out_tgt_l_in;
   logic               out_onoff_ff, out_onoff_in;
   logic               out_drive_ff, out_drive_in;
   logic               out_saved_ff, out_saved_in;
   logic               out_active_ff, out_active_in;

   logic [PROD_W-1:0]     prod_full;
   logic [DELAY5_W-1:0]   delay5;
   logic [CFG_W-1:0]      interval_eff;
   lft_div_cmd_type       div_cmd;
   logic [TIME_WIDTH-1:0] div_dividend;
   logic [TIME_WIDTH-1:0] div_divisor;
   logic                  div_busy;
   logic [TIME_WIDTH-1:0] div_quot;

   assign prod_full    = {{CFG_W{1'b0}}, tick_count_ff} * {{TICK_W{1'b0}}, period_ff};
   assign delay5       = {1'b0, req_delay_ff, 2'b00} + {3'b000, req_delay_ff};
   assign interval_eff = (interval_ff == '0) ? CFG_W'(1) : interval_ff;

   // Divider operand selection.
   always_comb begin
      div_cmd.go    = cmd.div_steps_go | cmd.div_light_go | cmd.div_temp_go;
      div_cmd.iters = CNT_W'(LEVEL_W);
      div_dividend  = '0;
      div_divisor   = steps_ff;
      if (cmd.div_steps_go) begin
         div_cmd.iters = CNT_W'(TIME_WIDTH);
         div_dividend  = end_ff - prod_ff;
         div_divisor   = {{(TIME_WIDTH-CFG_W){1'b0}}, interval_eff};
      end else if (cmd.div_light_go) begin
         div_dividend = {level_delta(cur_l_ff, tgt_l_ff), {(TIME_WIDTH-LEVEL_W){1'b0}}};
         div_divisor  = div_quot;
      end else if (cmd.div_temp_go) begin
         div_dividend = {level_delta(cur_t_ff, tgt_t_ff), {(TIME_WIDTH-LEVEL_W){1'b0}}};
         div_divisor  = steps_ff;
      end
   end

   lft_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_cmd  (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   always_comb begin
      period_in     = period_ff;
      interval_in   = interval_ff;
      tick_count_in = tick_count_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      cur_l_in      = cur_l_ff;
      cur_t_in      = cur_t_ff;
      tgt_l_in      = tgt_l_ff;
      tgt_t_in      = tgt_t_ff;
      tgt_onoff_in  = tgt_onoff_ff;
      saved_l_in    = saved_l_ff;
      saved_t_in    = saved_t_ff;
      drive_in      = drive_ff;
      saved_flag_in = saved_flag_ff;
      req_cmd_in    = req_cmd_ff;
      req_l_in      = req_l_ff;
      req_t_in      = req_t_ff;
      req_onoff_in  = req_onoff_ff;
      req_trans_in  = req_trans_ff;
      req_delay_in  = req_delay_ff;
      prod_in       = prod_ff;
      dur_in        = dur_ff;
      steps_in      = steps_ff;
      out_cur_l_in  = out_cur_l_ff;
      out_cur_t_in  = out_cur_t_ff;
      out_tgt_l_in  = out_tgt_l_ff;
      out_onoff_in  = out_onoff_ff;
      out_drive_in  = out_drive_ff;
      out_saved_in  = out_saved_ff;
      out_active_in = out_active_ff;

      if (csr_write_enable) begin
         unique case (lft_csr_type'(csr_index))
            CSR_TICK_PERIOD:   period_in   = csr_write_data;
            CSR_STEP_INTERVAL: interval_in = csr_write_data;
         endcase
      end

      if (cmd.load_req) begin
         req_cmd_in   = lft_cmd_code_type'(req_command);
         req_l_in     = req_lightness;
         req_t_in     = req_temperature;
         req_onoff_in = req_onoff_value;
         req_trans_in = req_transition_code;
         req_delay_in = req_delay_code;
         drive_in      = 1'b0;
         saved_flag_in = 1'b0;
         if (lft_cmd_code_type'(req_command) == CMD_TICK) begin
            tick_count_in = tick_count_ff + TICK_W'(1);
         end
      end

      if (cmd.calc_prod) begin
         prod_in = TIME_WIDTH'(prod_full);
      end

      if (cmd.apply_level) begin
         case (req_cmd_ff)
            CMD_SET_LEVEL: begin
               tgt_l_in     = req_l_ff;
               tgt_t_in     = req_t_ff;
               saved_l_in   = req_l_ff;
               saved_t_in   = req_t_ff;
               tgt_onoff_in = (req_l_ff != '0);
            end
            CMD_SET_ONOFF: begin
               tgt_onoff_in = req_onoff_ff;
               if (req_onoff_ff) begin
                  if (cur_l_ff == '0) begin
                     tgt_l_in = saved_l_ff;
                     tgt_t_in = saved_t_ff;
                  end
               end else begin
                  tgt_l_in = '0;
               end
            end
            default: ;
         endcase
      end

      if (cmd.set_start) begin
         start_in = prod_ff + {{(TIME_WIDTH-DELAY5_W){1'b0}}, delay5};
         dur_in   = duration_ms(req_trans_ff);
      end
      if (cmd.set_end) begin
         end_in = start_ff + {{(TIME_WIDTH-DUR_W){1'b0}}, dur_ff};
      end
      if (cmd.clear_start) begin
         start_in = '0;
      end
      if (cmd.clear_end) begin
         end_in = '0;
      end

      if (cmd.save) begin
         if (tgt_l_ff != '0) begin
            saved_l_in = tgt_l_ff;
         end
         if (tgt_t_ff != '0) begin
            saved_t_in = tgt_t_ff;
         end
      end
      if (cmd.snap) begin
         cur_l_in = tgt_l_ff;
         cur_t_in = tgt_t_ff;
      end

      if (cmd.div_light_go) begin
         steps_in = div_quot;
      end
      if (cmd.step_light) begin
         cur_l_in = level_step(cur_l_ff, tgt_l_ff, div_quot[LEVEL_W-1:0]);
      end
      if (cmd.step_temp) begin
         cur_t_in = level_step(cur_t_ff, tgt_t_ff, div_quot[LEVEL_W-1:0]);
      end

      if (cmd.set_drive) begin
         drive_in = 1'b1;
      end
      if (cmd.set_saved) begin
         saved_flag_in = 1'b1;
      end

      if (cmd.load_rsp) begin
         out_cur_l_in  = cur_l_ff;
         out_cur_t_in  = cur_t_ff;
         out_tgt_l_in  = tgt_l_ff;
         out_onoff_in  = tgt_onoff_ff;
         out_drive_in  = drive_ff;
         out_saved_in  = saved_flag_ff;
         out_active_in = (start_ff != '0) || (end_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      req_cmd_ff    <= req_cmd_in;
      req_l_ff      <= req_l_in;
      req_t_ff      <= req_t_in;
      req_onoff_ff  <= req_onoff_in;
      req_trans_ff  <= req_trans_in;
      req_delay_ff  <= req_delay_in;
      prod_ff       <= prod_in;
      dur_ff        <= dur_in;
      steps_ff      <= steps_in;
      out_cur_l_ff  <= out_cur_l_in;
      out_cur_t_ff  <= out_cur_t_in;
      out_tgt_l_ff  <= out_tgt_l_in;
      out_onoff_ff  <= out_onoff_in;
      out_drive_ff  <= out_drive_in;
      out_saved_ff  <= out_saved_in;
      out_active_ff <= out_active_in;
      if (reset) begin
         period_ff     <= TICK_PERIOD_RST;
         interval_ff   <= STEP_INTERVAL_RST;
         tick_count_ff <= '0;
         start_ff      <= '0;
         end_ff        <= '0;
         cur_l_ff      <= '0;
         cur_t_ff      <= TEMP_MIN;
         tgt_l_ff      <= LEVEL_MAX;
         tgt_t_ff      <= TEMP_MAX;
         tgt_onoff_ff  <= 1'b0;
         saved_l_ff    <= LEVEL_MAX;
         saved_t_ff    <= TEMP_MAX;
         drive_ff      <= 1'b0;
         saved_flag_ff <= 1'b0;
      end else begin
         period_ff     <= period_in;
         interval_ff   <= interval_in;
         tick_count_ff <= tick_count_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         cur_l_ff      <= cur_l_in;
         cur_t_ff      <= cur_t_in;
         tgt_l_ff      <= tgt_l_in;
         tgt_t_ff      <= tgt_t_in;
         tgt_onoff_ff  <= tgt_onoff_in;
         saved_l_ff    <= saved_l_in;
         saved_t_ff    <= saved_t_in;
         drive_ff      <= drive_in;
         saved_flag_ff <= saved_flag_in;
      end
   end

   always_comb begin
      status.command       = req_cmd_ff;
      status.none_pending  = (start_ff == '0) && (end_ff == '0);
      status.start_pending = (start_ff != '0);
      status.before_start  = (prod_ff < start_ff);
      status.at_target     = (cur_l_ff == tgt_l_ff) && (cur_t_ff == tgt_t_ff);
      status.end_after_now = (end_ff > prod_ff);
      status.trans_zero    = (req_trans_ff == '0);
      status.delay_zero    = (req_delay_ff == '0);
      status.div_idle      = !div_busy;
      status.steps_zero    = (div_quot == '0);
   end

   assign rsp_current_lightness    = out_cur_l_ff;
   assign rsp_current_temperature  = out_cur_t_ff;
   assign rsp_target_lightness_out = out_tgt_l_ff;
   assign rsp_target_onoff_out     = out_onoff_ff;
   assign rsp_drive_update         = out_drive_ff;
   assign rsp_state_saved          = out_saved_ff;
   assign rsp_transition_active    = out_active_ff;

endmodule

// ----- hdl/lft_ctrl.sv -----
`include "light_fade_transition_assert.svh"

module lft_ctrl
   import lft_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  lft_status_type status,
   output lft_cmd_type    cmd
);

   lft_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.calc_prod = 1'b1;
            unique case (status.command) inside
               CMD_TICK:  state_in = ST_TICK_START;
               CMD_START: state_in = ST_SET_START;
               CMD_SET_LEVEL, CMD_SET_ONOFF: begin
                  cmd.apply_level = 1'b1;
                  state_in        = ST_FINISH;
               end
            endcase
         end
         ST_SET_START: begin
            state_in = ST_FINISH;
            if (!(status.trans_zero && status.delay_zero)) begin
               cmd.set_start = 1'b1;
               if (!status.trans_zero) begin
                  state_in = ST_SET_END;
               end
            end
         end
         ST_SET_END: begin
            cmd.set_end = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_TICK_START: begin
            if (status.none_pending) begin
               state_in = ST_FINISH;
            end else if (status.start_pending && status.before_start) begin
               state_in = ST_FINISH;
            end else begin
               cmd.clear_start = 1'b1;
               state_in        = ST_TICK_EVAL;
            end
         end
         ST_TICK_EVAL: begin
            if (status.at_target) begin
               cmd.clear_end = 1'b1;
               cmd.save      = 1'b1;
               cmd.set_saved = 1'b1;
               state_in      = ST_FINISH;
            end else if (!status.end_after_now) begin
               cmd.snap      = 1'b1;
               cmd.clear_end = 1'b1;
               cmd.save      = 1'b1;
               cmd.set_drive = 1'b1;
               cmd.set_saved = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.div_steps_go = 1'b1;
               state_in         = ST_DIV_STEPS;
            end
         end
         ST_DIV_STEPS: begin
            if (status.div_idle) begin
               if (status.steps_zero) begin
                  cmd.snap      = 1'b1;
                  cmd.clear_end = 1'b1;
                  cmd.save      = 1'b1;
                  cmd.set_drive = 1'b1;
                  cmd.set_saved = 1'b1;
                  state_in      = ST_FINISH;
               end else begin
                  cmd.div_light_go = 1'b1;
                  state_in         = ST_DIV_LIGHT;
               end
            end
         end
         ST_DIV_LIGHT: begin
            if (status.div_idle) begin
               cmd.step_light  = 1'b1;
               cmd.div_temp_go = 1'b1;
               state_in        = ST_DIV_TEMP;
            end
         end
         ST_DIV_TEMP: begin
            if (status.div_idle) begin
               cmd.step_temp = 1'b1;
               cmd.set_drive = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `LFT_ASSERT_NEXT(a_accept_starts_work, clock, reset, req_valid && !req_stall, state_ff == ST_PROD)
   `LFT_ASSERT_NEXT(a_result_raised, clock, reset, cmd.load_rsp, rsp_valid_ff)
   `LFT_ASSERT_NEXT(a_finish_waits, clock, reset, (state_ff == ST_FINISH) && rsp_valid_ff && rsp_stall, state_ff == ST_FINISH)
   `LFT_ASSERT_SAME(a_div_start_idle, clock, reset, cmd.div_steps_go || cmd.div_light_go || cmd.div_temp_go, status.div_idle)

endmodule

// ----- hdl/light_fade_transition.sv -----
// Lamp fade engine for a lightness and color temperature lamp. Each item
// carries one event: a tick that advances time by tick_period_ms, new
// lightness and temperature targets, an on/off target, or the start of a
// transition with a delay code (5 ms units) and a transition time code.
// Every item returns exactly one result item with the present and target
// values and the drive_update, state_saved and transition_active flags.
// Items are handled one at a time. A set or on/off item passes through
// ST_PROD to ST_FINISH, a start item through ST_PROD, ST_SET_START and,
// for a nonzero transition code, ST_SET_END, a tick with nothing to do
// through ST_PROD and ST_TICK_START, and a tick that snaps or saves also
// through ST_TICK_EVAL. A tick that steps the fade runs the shared
// restoring divider three times: once over TIME_WIDTH bits for the step
// count and twice over 16 bits for the two deltas. The next item can be
// accepted in the cycle after the result register is loaded, and a
// stalled result holds the block in its last state until it can be loaded.
// The result register lets the next item be accepted while a finished
// result still waits on rsp_stall. Configuration writes take effect at
// once and are to be made while the block is idle.
module light_fade_transition
   import lft_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic [LEVEL_W-1:0]   req_lightness,
   input  logic [LEVEL_W-1:0]   req_temperature,
   input  logic                 req_onoff_value,
   input  logic [CODE_W-1:0]    req_transition_code,
   input  logic [CODE_W-1:0]    req_delay_code,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [LEVEL_W-1:0]   rsp_current_lightness,
   output logic [LEVEL_W-1:0]   rsp_current_temperature,
   output logic [LEVEL_W-1:0]   rsp_target_lightness_out,
   output logic                 rsp_target_onoff_out,
   output logic                 rsp_drive_update,
   output logic                 rsp_state_saved,
   output logic                 rsp_transition_active
);

   // The controller sequences each item; the datapath holds all lamp state,
   // the configuration registers, the divider and the result register.
   lft_cmd_type    cmd;
   lft_status_type status;

   lft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lft_dpath u_dpath (
      .clock                    (clock),
      .reset                    (reset),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .req_command              (req_command),
      .req_lightness            (req_lightness),
      .req_temperature          (req_temperature),
      .req_onoff_value          (req_onoff_value),
      .req_transition_code      (req_transition_code),
      .req_delay_code           (req_delay_code),
      .cmd                      (cmd),
      .status                   (status),
      .rsp_current_lightness    (rsp_current_lightness),
      .rsp_current_temperature  (rsp_current_temperature),
      .rsp_target_lightness_out (rsp_target_lightness_out),
      .rsp_target_onoff_out     (rsp_target_onoff_out),
      .rsp_drive_update         (rsp_drive_update),
      .rsp_state_saved          (rsp_state_saved),
      .rsp_transition_active    (rsp_transition_active)
   );

endmodule
